// ----- rtl/core/heightmap_bilinear_sampler_defines.svh -----
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler assertion macros
// Shared property wrappers for the checker of the sampler.
// ---------------------------------------------------------------------------
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define HBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define HBS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/hbs_pkg.sv -----
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler package
// Field widths, fixed-point constants and operation codes of the sampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbs_pkg;

  // Operation carried by an input beat.
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  // Field widths.
  localparam int IDX_W    = 12;
  localparam int HEIGHT_W = 16;
  localparam int COORD_W  = 24;
  localparam int SCALE_W  = 17;
  localparam int FRAC_W   = 16;

  // Height store geometry.
  localparam int STORE_DEPTH = 4096;

  // Default grid edge length in cells.
  localparam int GRID_SIZE_DEFAULT = 64;

  // Scale register resets to 1.0 in Q1.16.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 17'h10000;

  // 1.0 in Q1.16, one bit wider than a fraction.
  localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;

  // Signed world coordinate times unsigned scale: 25 x 18 bits.
  localparam int PROD_W = COORD_W + 1 + SCALE_W + 1;

  // Row blend: height times a Q1.16 weight, two terms.
  localparam int ROW_W = HEIGHT_W + FRAC_W + 2;

  // Full bilinear sum before rounding.
  localparam int SUM_W = 50;

endpackage

// ----- rtl/core/hbs_ram.sv -----
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered behind an enable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; the read data holds while the enable is low.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/heightmap_bilinear_sampler.sv -----
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler: each accepted query gives one result beat; a write gives none.
// Throughput one beat per cycle unless the output stalls, writes and queries mixed.
// Stages: scale multiply, clamp, corner read from four store copies, row blend,
// column blend, rounding into the output register. Reset clears the valid bits and
// sets the scale to 1.0; the height grid is not cleared and holds garbage until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heightmap_bilinear_sampler #(
  parameter int GRID_SIZE = hbs_pkg::GRID_SIZE_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration
  input  logic                               cfg_we_i,
  input  logic [hbs_pkg::SCALE_W-1:0]        cfg_wdata_i,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic [hbs_pkg::IDX_W-1:0]          cell_index_i,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] height_value_i,
  input  logic signed [hbs_pkg::COORD_W-1:0] query_x_i,
  input  logic signed [hbs_pkg::COORD_W-1:0] query_z_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] height_out_o,
  output logic                               was_clamped_o
);

  localparam int CW     = $clog2(GRID_SIZE);
  localparam int GW     = CW + hbs_pkg::FRAC_W;
  localparam int AW     = 2 * CW;
  localparam int XW     = (AW > hbs_pkg::IDX_W) ? AW : hbs_pkg::IDX_W + 1;
  localparam int PW     = hbs_pkg::PROD_W;
  localparam int HW     = hbs_pkg::HEIGHT_W;
  localparam int FW     = hbs_pkg::FRAC_W;
  localparam int RW     = hbs_pkg::ROW_W;
  localparam int SW     = hbs_pkg::SUM_W;
  localparam int NCORNER = 4;

  // Largest grid coordinate, (GRID_SIZE - 1) cells in Q.16.
  localparam logic [PW-10:0] LIM = (PW-9)'(GRID_SIZE - 1) << FW;
  localparam logic [CW-1:0]  LAST_CELL = CW'(GRID_SIZE - 1);

  typedef struct packed {
    logic [GW-1:0] coord;
    logic          clamped;
  } grid_t;

  typedef struct packed {
    logic                     oob;
    logic [hbs_pkg::IDX_W-1:0] idx;
  } addr_t;

  // Clamp a scaled product into the grid and drop the extra fraction bits.
  function automatic grid_t to_grid(input logic signed [PW-1:0] p);
    logic [PW-10:0] g;
    grid_t          r;
    g = p[PW-2:8];
    r.clamped = 1'b0;
    if (p[PW-1]) begin
      r.coord   = '0;
      r.clamped = 1'b1;
    end else if (g > LIM) begin
      r.coord   = LIM[GW-1:0];
      r.clamped = 1'b1;
    end else begin
      r.coord = g[GW-1:0];
    end
    return r;
  endfunction

  // Linear store address of a grid cell; beyond the store it reads as zero.
  function automatic addr_t cell_addr(input logic [CW-1:0] row, input logic [CW-1:0] col);
    logic [XW-1:0] a;
    addr_t         r;
    a = XW'(row) * XW'(GRID_SIZE) + XW'(col);
    r.oob = (a >= XW'(hbs_pkg::STORE_DEPTH));
    r.idx = a[hbs_pkg::IDX_W-1:0];
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  logic [hbs_pkg::SCALE_W-1:0] scale_q;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, out_valid_q;
  logic s1_query_q, s2_query_q;

  // Stage 1: scaled coordinates, or the write beat.
  logic signed [PW-1:0]       s1_px_q, s1_pz_q;
  logic [hbs_pkg::IDX_W-1:0]  s1_idx_q;
  logic signed [HW-1:0]       s1_height_q;
  // Stage 2: clamped grid coordinates; memory access happens here.
  grid_t                      s2_gx_q, s2_gz_q;
  logic [hbs_pkg::IDX_W-1:0]  s2_idx_q;
  logic signed [HW-1:0]       s2_height_q;
  // Stage 3: fractions next to the corner read data.
  logic [FW-1:0]              s3_tx_q, s3_ty_q;
  logic [NCORNER-1:0]         s3_oob_q;
  logic                       s3_clamped_q;
  // Stage 4: row blends.
  logic signed [RW-1:0]       s4_top_q, s4_bot_q;
  logic [FW-1:0]              s4_ty_q;
  logic                       s4_clamped_q;
  // Stage 5: full sum.
  logic signed [SW-1:0]       s5_sum_q;
  logic                       s5_clamped_q;
  // Output beat.
  logic signed [HW-1:0]       out_height_q;
  logic                       out_clamped_q;

  // -------------------------------------------------------------------------
  // Pipeline enables: a stage loads when it is empty or its content moves on.
  // A write leaves stage 2 into the store and never waits.
  // -------------------------------------------------------------------------
  logic en_out, en5, en4, en3, en2, en1;

  assign en_out = !out_valid_q || !out_stall_i;
  assign en5    = !s5_valid_q || en_out;
  assign en4    = !s4_valid_q || en5;
  assign en3    = !s3_valid_q || en4;
  assign en2    = !s2_valid_q || !s2_query_q || en3;
  assign en1    = !s1_valid_q || en2;

  assign in_stall_o = !en1;

  // -------------------------------------------------------------------------
  // Stage 1 datapath: world position times reciprocal cell size.
  // -------------------------------------------------------------------------
  logic signed [hbs_pkg::COORD_W:0] x_ext, z_neg;
  logic signed [PW-1:0]             px_d, pz_d;

  assign x_ext = {query_x_i[hbs_pkg::COORD_W-1], query_x_i};
  assign z_neg = -$signed({query_z_i[hbs_pkg::COORD_W-1], query_z_i});
  assign px_d  = x_ext * $signed({1'b0, scale_q});
  assign pz_d  = z_neg * $signed({1'b0, scale_q});

  // -------------------------------------------------------------------------
  // Stage 2 datapath: corner addresses with wrap at the far edge.
  // -------------------------------------------------------------------------
  grid_t           gx_d, gz_d;
  logic [CW-1:0]   c0, r0, c1, r1;
  addr_t           corner [NCORNER];
  logic [hbs_pkg::IDX_W-1:0] raddr [NCORNER];
  logic [HW-1:0]   rdata [NCORNER];
  logic            store_we;

  assign gx_d = to_grid(s1_px_q);
  assign gz_d = to_grid(s1_pz_q);

  assign c0 = s2_gx_q.coord[GW-1:FW];
  assign r0 = s2_gz_q.coord[GW-1:FW];
  assign c1 = (c0 == LAST_CELL) ? '0 : c0 + CW'(1);
  assign r1 = (r0 == LAST_CELL) ? '0 : r0 + CW'(1);

  // Corner order: top left, top right, bottom right, bottom left.
  assign corner[0] = cell_addr(r0, c0);
  assign corner[1] = cell_addr(r0, c1);
  assign corner[2] = cell_addr(r1, c1);
  assign corner[3] = cell_addr(r1, c0);

  assign store_we = s2_valid_q && !s2_query_q;

  // One store copy per corner; every write goes to all copies.
  for (genvar k = 0; k < NCORNER; k++) begin : g_bank
    assign raddr[k] = corner[k].idx;

    hbs_ram #(
      .WIDTH (HW),
      .DEPTH (hbs_pkg::STORE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (store_we),
      .waddr_i (s2_idx_q),
      .wdata_i (s2_height_q),
      .re_i    (en3),
      .raddr_i (raddr[k]),
      .rdata_o (rdata[k])
    );
  end

  // -------------------------------------------------------------------------
  // Stage 3 datapath: blend along x within each row.
  // -------------------------------------------------------------------------
  logic signed [HW-1:0]   h [NCORNER];
  logic signed [FW+1:0]   wx0, wx1;
  logic signed [RW-1:0]   top_d, bot_d;

  for (genvar k = 0; k < NCORNER; k++) begin : g_zero
    assign h[k] = s3_oob_q[k] ? '0 : $signed(rdata[k]);
  end

  assign wx0   = $signed({1'b0, hbs_pkg::ONE_Q16 - {1'b0, s3_tx_q}});
  assign wx1   = $signed({2'b00, s3_tx_q});
  assign top_d = h[0] * wx0 + h[1] * wx1;
  assign bot_d = h[3] * wx0 + h[2] * wx1;

  // -------------------------------------------------------------------------
  // Stage 4 datapath: blend the two rows along z.
  // -------------------------------------------------------------------------
  logic signed [FW+1:0] wy0, wy1;
  logic signed [SW-1:0] sum_d;

  assign wy0   = $signed({1'b0, hbs_pkg::ONE_Q16 - {1'b0, s4_ty_q}});
  assign wy1   = $signed({2'b00, s4_ty_q});
  assign sum_d = s4_top_q * wy0 + s4_bot_q * wy1;

  // -------------------------------------------------------------------------
  // Stage 5 datapath: round half up to Q8.8 and saturate.
  // -------------------------------------------------------------------------
  localparam logic signed [SW-1:0] HALF = SW'(64'd1 << 31);
  localparam int                   RSW  = SW - 32;

  logic signed [SW-1:0]  rounded;
  logic signed [RSW-1:0] res;
  logic signed [HW-1:0]  height_d;

  assign rounded = s5_sum_q + HALF;
  assign res     = rounded[SW-1:32];

  always_comb begin
    if (res > RSW'(32767)) begin
      height_d = 16'sh7fff;
    end else if (res < -RSW'(32768)) begin
      height_d = -16'sh8000;
    end else begin
      height_d = res[HW-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Control registers.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= hbs_pkg::SCALE_RESET;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      s1_query_q  <= 1'b0;
      s2_query_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (en1) begin
        s1_valid_q <= in_valid_i;
        s1_query_q <= (mode_i == hbs_pkg::MODE_QUERY);
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
        s2_query_q <= s1_query_q;
      end
      if (en3) begin
        s3_valid_q <= s2_valid_q && s2_query_q;
      end
      if (en4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (en5) begin
        s5_valid_q <= s4_valid_q;
      end
      if (en_out) begin
        out_valid_q <= s5_valid_q;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Payload registers.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_px_q     <= px_d;
      s1_pz_q     <= pz_d;
      s1_idx_q    <= cell_index_i;
      s1_height_q <= height_value_i;
    end
    if (en2) begin
      s2_gx_q     <= gx_d;
      s2_gz_q     <= gz_d;
      s2_idx_q    <= s1_idx_q;
      s2_height_q <= s1_height_q;
    end
    if (en3) begin
      s3_tx_q      <= s2_gx_q.coord[FW-1:0];
      s3_ty_q      <= s2_gz_q.coord[FW-1:0];
      s3_oob_q     <= {corner[3].oob, corner[2].oob, corner[1].oob, corner[0].oob};
      s3_clamped_q <= s2_gx_q.clamped || s2_gz_q.clamped;
    end
    if (en4) begin
      s4_top_q     <= top_d;
      s4_bot_q     <= bot_d;
      s4_ty_q      <= s3_ty_q;
      s4_clamped_q <= s3_clamped_q;
    end
    if (en5) begin
      s5_sum_q     <= sum_d;
      s5_clamped_q <= s4_clamped_q;
    end
    if (en_out) begin
      out_height_q  <= height_d;
      out_clamped_q <= s5_clamped_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign height_out_o  = out_height_q;
  assign was_clamped_o = out_clamped_q;

endmodule

// ----- rtl/core/hbs_checker.sv -----
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler checker
// Port-level properties of the sampler, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_defines.svh"

module hbs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [hbs_pkg::HEIGHT_W-1:0] height_out_o,
  input logic                               was_clamped_o
);

  // A stalled result beat stays offered.
  `HBS_ASSERT(a_out_valid_hold, out_valid_o && out_stall_i |=> out_valid_o, "result beat dropped while stalled")

  // A stalled result beat keeps its payload.
  `HBS_ASSERT(a_out_data_hold, out_valid_o && out_stall_i |=> $stable(height_out_o) && $stable(was_clamped_o), "result payload changed while stalled")

  // With the output free, the whole pipeline advances and the input is taken.
  `HBS_ASSERT(a_no_stall_when_free, !out_valid_o || !out_stall_i |-> !in_stall_o, "input stalled while the output side was free")

  // Reset empties the pipeline.
  `HBS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result beat right after reset")

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (.*);

// ----- sim/heightmap_bilinear_sampler_tb.sv -----
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler testbench
// Loads terrain heights and sends world-position queries through the valid/stall
// channels, then checks every result beat against a fixed-point model of the
// sampler. A short directed set covers the height extremes and the edge wrap.
// It also covers clamping on every side and the rounding tie. Random phases
// follow with several scale settings; the first four add random idles and stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_tb;

  localparam int                     IDX_W       = hbs_pkg::IDX_W;
  localparam int                     HEIGHT_W    = hbs_pkg::HEIGHT_W;
  localparam int                     COORD_W     = hbs_pkg::COORD_W;
  localparam int                     SCALE_W     = hbs_pkg::SCALE_W;
  localparam int                     FRAC_W      = hbs_pkg::FRAC_W;
  localparam int                     STORE_DEPTH = hbs_pkg::STORE_DEPTH;
  localparam logic [SCALE_W-1:0]     SCALE_RESET = hbs_pkg::SCALE_RESET;

  localparam int     GRID        = hbs_pkg::GRID_SIZE_DEFAULT;
  localparam longint UNIT        = longint'(hbs_pkg::ONE_Q16);
  localparam longint GRID_LIM    = longint'(GRID - 1) * UNIT;
  localparam longint COORD_MAX   = 64'sd8388607;
  localparam int     CYCLE_LIMIT = 400000;

  // One input beat as the driver presents it.
  typedef struct packed {
    hbs_pkg::mode_e             mode;
    logic [IDX_W-1:0]           cell_idx;
    logic signed [HEIGHT_W-1:0] height;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  z;
  } sampler_beat_t;

  // One result beat.
  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic                       clamped;
  } height_sample_t;

  // Corner addresses (00, 01, 11, 10) and fractions of one query.
  typedef struct packed {
    logic [3:0][IDX_W-1:0] corner;
    logic [FRAC_W-1:0]     tx;
    logic [FRAC_W-1:0]     ty;
    logic                  clamped;
  } sample_site_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_we_i       = 1'b0;
  logic [SCALE_W-1:0]         cfg_wdata_i    = '0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic                       mode_i         = 1'b0;
  logic [IDX_W-1:0]           cell_index_i   = '0;
  logic signed [HEIGHT_W-1:0] height_value_i = '0;
  logic signed [COORD_W-1:0]  query_x_i      = '0;
  logic signed [COORD_W-1:0]  query_z_i      = '0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic signed [HEIGHT_W-1:0] height_out_o;
  logic                       was_clamped_o;

  // Model state: scale register and a copy of the height grid.
  logic [SCALE_W-1:0]         cell_scale = SCALE_RESET;
  logic signed [HEIGHT_W-1:0] grid_heights [STORE_DEPTH];

  // Cells that the generated stimulus has loaded so far.
  bit loaded_cells [STORE_DEPTH];

  sampler_beat_t  pending_beats [$];
  height_sample_t expected_heights [$];
  sampler_beat_t  shown;
  int             queued         = 0;
  int             n_fail         = 0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             cycle_count    = 0;

  heightmap_bilinear_sampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .cell_index_i  (cell_index_i),
    .height_value_i(height_value_i),
    .query_x_i     (query_x_i),
    .query_z_i     (query_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .height_out_o  (height_out_o),
    .was_clamped_o (was_clamped_o)
  );

  always #2 clk_i = ~clk_i;

  // Scale both world coordinates to grid units, clamp them and find the cell.
  function automatic sample_site_t locate(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] z,
                                          input logic [SCALE_W-1:0] scale);
    sample_site_t s;
    longint       w [2];
    longint       g [2];
    longint       prod, c0, r0, c1, r1;
    s = '0;
    w[0] = longint'(x);
    w[1] = -longint'(z);
    for (int k = 0; k < 2; k++) begin
      prod = w[k] * longint'(scale);
      if (prod < 0) begin
        s.clamped = 1'b1;
        g[k] = 0;
      end else begin
        g[k] = prod >>> 8;
        if (g[k] > GRID_LIM) begin
          s.clamped = 1'b1;
          g[k] = GRID_LIM;
        end
      end
    end
    c0 = g[0] >>> 16;
    r0 = g[1] >>> 16;
    // A neighbor off the far edge wraps to index zero.
    c1 = (c0 + 1 >= GRID) ? 0 : c0 + 1;
    r1 = (r0 + 1 >= GRID) ? 0 : r0 + 1;
    s.corner[0] = IDX_W'(r0 * GRID + c0);
    s.corner[1] = IDX_W'(r0 * GRID + c1);
    s.corner[2] = IDX_W'(r1 * GRID + c1);
    s.corner[3] = IDX_W'(r1 * GRID + c0);
    s.tx = g[0][FRAC_W-1:0];
    s.ty = g[1][FRAC_W-1:0];
    return s;
  endfunction

  // Bilinear blend of the four corners, rounded half up to Q8.8 and saturated.
  function automatic height_sample_t predict_height(input sampler_beat_t b);
    sample_site_t   s;
    height_sample_t r;
    longint         wt [4];
    longint         tx, ty, acc, rounded;
    s  = locate(b.x, b.z, cell_scale);
    tx = longint'(s.tx);
    ty = longint'(s.ty);
    wt[0] = (UNIT - tx) * (UNIT - ty);
    wt[1] = tx * (UNIT - ty);
    wt[2] = tx * ty;
    wt[3] = (UNIT - tx) * ty;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      acc += longint'(grid_heights[s.corner[k]]) * wt[k];
    end
    rounded = (acc + 64'sd2147483648) >>> 32;
    if (rounded > 32767) rounded = 32767;
    if (rounded < -32768) rounded = -32768;
    r.height  = rounded[HEIGHT_W-1:0];
    r.clamped = s.clamped;
    return r;
  endfunction

  // Queue a height write; the unused query fields carry random bits.
  task automatic add_write(input logic [IDX_W-1:0] idx, input logic [HEIGHT_W-1:0] h);
    sampler_beat_t b;
    b.mode     = hbs_pkg::MODE_WRITE;
    b.cell_idx = idx;
    b.height   = h;
    b.x        = COORD_W'($urandom);
    b.z        = COORD_W'($urandom);
    pending_beats.push_back(b);
    loaded_cells[idx] = 1'b1;
    queued++;
  endtask

  // Queue a query, loading first any corner that was never written.
  task automatic add_query(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] z);
    sampler_beat_t b;
    sample_site_t  s;
    s = locate(x, z, cell_scale);
    for (int k = 0; k < 4; k++) begin
      if (!loaded_cells[s.corner[k]]) add_write(s.corner[k], HEIGHT_W'($urandom));
    end
    b.mode     = hbs_pkg::MODE_QUERY;
    b.cell_idx = IDX_W'($urandom);
    b.height   = HEIGHT_W'($urandom);
    b.x        = x;
    b.z        = z;
    pending_beats.push_back(b);
    queued++;
  endtask

  // Random mix: writes, queries inside the grid and queries anywhere.
  task automatic add_random_beats(input int count);
    int     first, roll, xq, zq;
    longint span;
    first = queued;
    if (cell_scale == 0) begin
      span = COORD_MAX;
    end else begin
      span = (GRID_LIM <<< 8) / longint'(cell_scale);
      if (span > COORD_MAX) span = COORD_MAX;
    end
    while (queued - first < count) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        add_write(IDX_W'($urandom), HEIGHT_W'($urandom));
      end else if (roll < 85) begin
        xq = ($urandom_range(9) == 0) ? int'(span) : int'($urandom_range(int'(span)));
        zq = ($urandom_range(9) == 0) ? int'(span) : int'($urandom_range(int'(span)));
        add_query(COORD_W'(xq), COORD_W'(-zq));
      end else begin
        add_query(COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  // Wait until every beat is accepted and every result has come back.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || expected_heights.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Input driver: holds a stalled beat, otherwise presents the next one or idles.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (shown.mode == hbs_pkg::MODE_QUERY) begin
          expected_heights.push_back(predict_height(shown));
        end else begin
          grid_heights[shown.cell_idx] = shown.height;
        end
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown = pending_beats.pop_front();
          in_valid_i     <= 1'b1;
          mode_i         <= shown.mode;
          cell_index_i   <= shown.cell_idx;
          height_value_i <= shown.height;
          query_x_i      <= shown.x;
          query_z_i      <= shown.z;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    height_sample_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_heights.size() == 0) begin
          $error("unexpected result beat: height_out=%0d was_clamped=%0b",
                 height_out_o, was_clamped_o);
          n_fail++;
        end else begin
          want = expected_heights.pop_front();
          if (height_out_o !== want.height) begin
            $error("height_out: expected %0d, actual %0d", $signed(want.height),
                   height_out_o);
            n_fail++;
          end
          if (was_clamped_o !== want.clamped) begin
            $error("was_clamped: expected %0b, actual %0b", want.clamped, was_clamped_o);
            n_fail++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus: reset, directed beats, then random phases over several scales.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        // Writes leave no result, so let the pipeline empty before the register moves.
        repeat (8) @(posedge clk_i);
        case (ph)
          1:       cell_scale = 17'd1;
          2:       cell_scale = 17'd0;
          3:       cell_scale = 17'h10000;
          4:       cell_scale = SCALE_W'($urandom_range(65535, 4096));
          default: cell_scale = SCALE_W'($urandom_range(65536, 1));
        endcase
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= cell_scale;
        @(posedge clk_i);
        cfg_we_i    <= 1'b0;
      end
      send_idle_pct  <= (ph < 2) ? 20 : (ph < 4) ? 64 : 0;
      recv_stall_pct <= (ph < 2) ? 64 : (ph < 4) ? 20 : 0;
      if (ph == 0) begin
        // Height extremes around the first cell and at the grid corners.
        add_write(12'd0, 16'sh7FFF);
        add_write(12'd1, 16'sh8000);
        add_write(12'd64, 16'sh8000);
        add_write(12'd65, 16'sh7FFF);
        add_write(12'd63, 16'sh00FF);
        add_write(12'd127, 16'sh7F00);
        add_write(12'd4032, 16'shFFFF);
        add_write(12'd4095, 16'sh8001);
        add_write(12'd4094, 16'sh0000);
        // Exact grid point, rounding ties, clamping on each side, edge wrap.
        add_query(24'sd0, 24'sd0);
        add_query(24'sd128, 24'sd0);
        add_query(24'sd128, -24'sd128);
        add_query(-24'sd1, 24'sd1);
        add_query(24'sd16128, 24'sd0);
        add_query(24'sd16328, -24'sd16328);
        add_query(24'sh7FFFFF, 24'sh800000);
        add_query(24'sh800000, 24'sh7FFFFF);
        add_query(24'sd100, -24'sd37);
      end
      add_random_beats(155);
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
